// ===== rtl/gts_pkg.sv =====
// Shared types and constants for the gesture template scorer.
package gts_pkg;

  localparam int IDX_W    = 5;
  localparam int ANGLE_W  = 16;
  localparam int SPREAD_W = 16;
  localparam int GAIN_W   = 12;
  localparam int TOL_W    = 20;
  localparam int SUM_W    = 25;
  localparam int SCORE_W  = 16;
  localparam int COUNT_W  = 5;
  localparam int QUOT_W   = 17;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [GAIN_W-1:0]  GAIN_RESET      = 12'd256;
  localparam logic [CFG_W-1:0]   MIN_TOL_RESET   = 16'd192;
  localparam logic [CFG_W-1:0]   THRESHOLD_RESET = 16'd57672;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_SCORE = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPREAD_GAIN    = 2'd0,
    REG_MIN_TOLERANCE  = 2'd1,
    REG_PASS_THRESHOLD = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_ACCUM,
    ST_SETUP,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                       opcode;
    logic [IDX_W-1:0]           feature_index;
    logic signed [ANGLE_W-1:0]  angle_value;
    logic [SPREAD_W-1:0]        spread_value;
    logic                       is_present;
    logic                       last_element;
  } in_word_t;

  typedef struct packed {
    logic [SCORE_W-1:0] match_score;
    logic               match_pass;
    logic [COUNT_W-1:0] features_used;
  } out_word_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [SUM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/gts_if.sv =====
// Valid/ready channel interfaces for the input and result words.
interface gts_in_if import gts_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface gts_out_if import gts_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/gts_divider.sv =====
// Restoring divider: (dividend << 16) / divisor, one quotient bit per cycle.
module gts_divider import gts_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam logic [COUNT_W-1:0] LAST_STEP = COUNT_W'(QUOT_W - 1);

  logic                busy;
  logic [COUNT_W-1:0]  step;
  logic [SUM_W:0]      rem;
  logic [SUM_W-1:0]    den;
  logic [QUOT_W-1:0]   quot;
  logic                done;
  logic [SUM_W:0]      trial;
  logic                fits;

  // The dividend never exceeds the divisor, so the first step needs no shift.
  always_comb begin
    trial = (step == '0) ? rem : {rem[SUM_W-1:0], 1'b0};
    fits  = (trial >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && (step == LAST_STEP);
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == LAST_STEP) begin
          busy <= 1'b0;
        end
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= {1'b0, req.dividend};
      den  <= req.divisor;
      quot <= '0;
    end else if (busy) begin
      rem  <= fits ? (trial - {1'b0, den}) : trial;
      quot <= {quot[QUOT_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quot;

endmodule

// ===== rtl/gesture_template_scorer_core.sv =====
// Top level of the gesture template scorer: template store, accumulator and score unit.
//
// Usage: template entries and feature elements arrive as words on the item channel
// (valid/ready). A load word (opcode load) writes mean, spread and the present flag of
// one template entry as it is accepted. A score word carries one feature element; it
// passes accept and template read, tolerance multiply, then clip and
// accumulate. Loads are taken one per cycle while the block is idle; a score element
// must finish before the next word is taken, since ready is high only when idle.
// A score word marked last then passes the setup state, the bit-serial divider and
// the emit state before its result word leaves on the result channel; the divider is
// skipped when the tolerance sum is zero. The result sits in an output register, so
// the next vector's elements are taken while a result waits; only a second last
// element holds in the emit state until the receiver has drained the first result.
// Configuration: wr_en/wr_index/wr_data write spread_gain (0), min_tolerance (1) and
// pass_threshold (2); write only while the block is idle.
// Reset clears the template present flags, the running sums, the count and both
// channels, and restores the configuration defaults. Template mean and spread memory
// is not cleared; an entry reads only after a load has marked it present.
module gesture_template_scorer_core import gts_pkg::*; #(
  parameter int NUM_FEATURES = 21
) (
  input  logic                 clk,
  input  logic                 rst,
  gts_in_if.sink               item,
  gts_out_if.source            result,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data
);

  localparam int AW = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;

  // Configuration registers
  logic [GAIN_W-1:0] spread_gain;
  logic [CFG_W-1:0]  min_tolerance;
  logic [CFG_W-1:0]  pass_threshold;

  // Template store: mean in the upper half, spread in the lower half
  logic [ANGLE_W+SPREAD_W-1:0] tmpl_mem [NUM_FEATURES];
  logic [ANGLE_W+SPREAD_W-1:0] tmpl_rd;
  logic [NUM_FEATURES-1:0]     tmpl_valid;

  state_t state, state_next;

  logic                      item_accept;
  logic                      in_range;
  logic [AW-1:0]             addr;
  logic                      slot_free;

  // Captured element
  logic signed [ANGLE_W-1:0] angle_q;
  logic                      used_q;
  logic                      last_q;

  // Datapath stage registers
  logic [TOL_W-1:0]          tol_raw;
  logic signed [ANGLE_W:0]   diff_q;
  logic [GAIN_W+SPREAD_W-1:0] product;

  logic [TOL_W-1:0]          tol;
  logic [ANGLE_W:0]          abs_diff;
  logic [TOL_W-1:0]          err;
  logic [SUM_W:0]            err_add;
  logic [SUM_W:0]            tol_add;

  // Running sums
  logic [SUM_W-1:0]          error_sum;
  logic [SUM_W-1:0]          tolerance_sum;
  logic [COUNT_W-1:0]        used_count;

  logic [SCORE_W-1:0]        score;
  logic [SCORE_W-1:0]        score_from_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  out_word_t res_word;
  logic      res_valid;

  assign item_accept = item.valid && item.ready;
  assign in_range    = ({1'b0, item.payload.feature_index} < (IDX_W + 1)'(NUM_FEATURES));
  assign addr        = item.payload.feature_index[AW-1:0];
  assign slot_free   = !res_valid || result.ready;

  assign item.ready     = (state == ST_IDLE);
  assign result.valid   = res_valid;
  assign result.payload = res_word;

  // Configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      spread_gain    <= GAIN_RESET;
      min_tolerance  <= MIN_TOL_RESET;
      pass_threshold <= THRESHOLD_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_SPREAD_GAIN:    spread_gain    <= wr_data[GAIN_W-1:0];
        REG_MIN_TOLERANCE:  min_tolerance  <= wr_data;
        REG_PASS_THRESHOLD: pass_threshold <= wr_data;
        default: ;
      endcase
    end
  end

  // Template memory: write on load, registered read on every accepted word.
  // One word is in flight at a time, so a read never overlaps a pending write.
  always_ff @(posedge clk) begin
    if (item_accept && (item.payload.opcode == OP_LOAD) && in_range) begin
      tmpl_mem[addr] <= {item.payload.angle_value, item.payload.spread_value};
    end
    if (item_accept) begin
      tmpl_rd <= tmpl_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tmpl_valid <= '0;
    end else if (item_accept && (item.payload.opcode == OP_LOAD) && in_range) begin
      tmpl_valid[addr] <= item.payload.is_present;
    end
  end

  // Capture the score element
  always_ff @(posedge clk) begin
    if (item_accept) begin
      angle_q <= item.payload.angle_value;
      used_q  <= item.payload.is_present && in_range && tmpl_valid[addr];
      last_q  <= item.payload.last_element;
    end
  end

  // Fetch stage: scale spread, take the raw difference
  assign product = {{SPREAD_W{1'b0}}, spread_gain}
                 * {{GAIN_W{1'b0}}, tmpl_rd[SPREAD_W-1:0]};

  always_ff @(posedge clk) begin
    if (state == ST_FETCH) begin
      tol_raw <= product[GAIN_W+SPREAD_W-1:8];
      diff_q  <= {angle_q[ANGLE_W-1], angle_q}
               - {tmpl_rd[ANGLE_W+SPREAD_W-1], tmpl_rd[ANGLE_W+SPREAD_W-1:SPREAD_W]};
    end
  end

  // Accumulate stage: floor the tolerance, clip the error
  always_comb begin
    tol      = (tol_raw < {{(TOL_W-CFG_W){1'b0}}, min_tolerance})
             ? {{(TOL_W-CFG_W){1'b0}}, min_tolerance} : tol_raw;
    abs_diff = diff_q[ANGLE_W] ? (~diff_q + 1'b1) : diff_q;
    err      = ({{(TOL_W-ANGLE_W-1){1'b0}}, abs_diff} > tol)
             ? tol : {{(TOL_W-ANGLE_W-1){1'b0}}, abs_diff};
    err_add  = {1'b0, error_sum} + {{(SUM_W-TOL_W+1){1'b0}}, err};
    tol_add  = {1'b0, tolerance_sum} + {{(SUM_W-TOL_W+1){1'b0}}, tol};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum     <= '0;
      tolerance_sum <= '0;
      used_count    <= '0;
    end else if (state == ST_ACCUM && used_q) begin
      error_sum     <= err_add[SUM_W] ? SUM_MAX : err_add[SUM_W-1:0];
      tolerance_sum <= tol_add[SUM_W] ? SUM_MAX : tol_add[SUM_W-1:0];
      if (used_count != COUNT_MAX) begin
        used_count <= used_count + 1'b1;
      end
    end else if (state == ST_EMIT && slot_free) begin
      error_sum     <= '0;
      tolerance_sum <= '0;
      used_count    <= '0;
    end
  end

  // Score: 1 - quotient, zero at a full quotient, saturate the all-match case
  always_comb begin
    if (div_rsp.quotient[QUOT_W-1]) begin
      score_from_q = '0;
    end else if (div_rsp.quotient == '0) begin
      score_from_q = '1;
    end else begin
      score_from_q = SCORE_W'(~div_rsp.quotient + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SETUP && tolerance_sum == '0) begin
      score <= '0;
    end else if (state == ST_DIVIDE && div_rsp.done) begin
      score <= score_from_q;
    end
  end

  assign div_req.start    = (state == ST_SETUP) && (tolerance_sum != '0);
  assign div_req.dividend = error_sum;
  assign div_req.divisor  = tolerance_sum;

  gts_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_EMIT && slot_free) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && slot_free) begin
      res_word.match_score   <= score;
      res_word.match_pass    <= (score >= pass_threshold);
      res_word.features_used <= used_count;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_accept && item.payload.opcode == OP_SCORE) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH:  state_next = ST_ACCUM;
      ST_ACCUM:  state_next = last_q ? ST_SETUP : ST_IDLE;
      ST_SETUP:  state_next = (tolerance_sum == '0) ? ST_EMIT : ST_DIVIDE;
      ST_DIVIDE: begin
        if (div_rsp.done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  // Each clipped error is at most its tolerance, saturation included
  a_err_le_tol: assert property (@(posedge clk) disable iff (rst)
    error_sum <= tolerance_sum)
    else $error("error sum exceeds tolerance sum");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == ST_DIVIDE)
    else $error("divider finished outside the divide state");

  a_clear_after_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && slot_free) |=>
      (error_sum == '0 && tolerance_sum == '0 && used_count == '0 && result.valid))
    else $error("sums not cleared or result missing after emit");

  a_score_starts_fetch: assert property (@(posedge clk) disable iff (rst)
    (item_accept && item.payload.opcode == OP_SCORE) |=> state == ST_FETCH)
    else $error("score word did not start a template fetch");
`endif

endmodule
